@@ rtl/wfhp_pkg.sv @@
// ----------------------------------------------------------------------------
// wfhp_pkg
// Shared types and constants for the wave file header parser.
// ----------------------------------------------------------------------------
package wfhp_pkg;

  // little-endian tag words
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_FACT = 32'h7463_6166;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_BASE_LEN = 32'd16;
  localparam logic [31:0] FMT_EXT_BASE = 32'd18;
  localparam logic [15:0] EXT_MIN_LEN  = 16'd8;

  localparam int OUT_TDATA_W = 288;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RIFF     = 3'd1;
  localparam logic [2:0] ST_WAVE_FMT = 3'd2;
  localparam logic [2:0] ST_FMT      = 3'd3;
  localparam logic [2:0] ST_FACT_TAG = 3'd4;
  localparam logic [2:0] ST_FACT     = 3'd5;
  localparam logic [2:0] ST_DATA_TAG = 3'd6;
  localparam logic [2:0] ST_SHORT    = 3'd7;

  typedef enum logic [11:0] {
    PH_IDLE     = 12'b0000_0000_0001,
    PH_RIFF     = 12'b0000_0000_0010,
    PH_FSIZE    = 12'b0000_0000_0100,
    PH_WAVE     = 12'b0000_0000_1000,
    PH_FMTID    = 12'b0000_0001_0000,
    PH_FMTSIZE  = 12'b0000_0010_0000,
    PH_FMT      = 12'b0000_0100_0000,
    PH_FACTID   = 12'b0000_1000_0000,
    PH_FACTSIZE = 12'b0001_0000_0000,
    PH_FACT     = 12'b0010_0000_0000,
    PH_DATAID   = 12'b0100_0000_0000,
    PH_DATASIZE = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] channel_mask;
    logic [31:0] fact_sample_count;
    logic [31:0] data_size;
    logic [31:0] data_offset;
    logic [31:0] file_size;
  } result_t;

endpackage

@@ rtl/wfhp_in_stage.sv @@
// ----------------------------------------------------------------------------
// wfhp_in_stage
// Input register for the header byte stream.
// ----------------------------------------------------------------------------
module wfhp_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  wfhp_pkg::in_item_t in_item,
  input  logic               take,
  output logic               held_valid,
  output wfhp_pkg::in_item_t held_item
);
  import wfhp_pkg::*;

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

@@ rtl/wfhp_parser.sv @@
// ----------------------------------------------------------------------------
// wfhp_parser
// Parser state and per-byte next-state logic; flags a result when one is due.
// ----------------------------------------------------------------------------
module wfhp_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  wfhp_pkg::in_item_t item,
  output logic               res_valid,
  output wfhp_pkg::result_t  res
);
  import wfhp_pkg::*;

  phase_t      phase, phase_next, cur;
  logic [31:0] offset, offset_next;
  logic [31:0] chunk_left, chunk_left_next;
  logic [31:0] chunk_pos, chunk_pos_next;
  logic [23:0] asm_lo, asm_lo_next;
  logic [1:0]  byte_idx, byte_idx_next;
  logic [15:0] ext_len, ext_len_next;
  logic [15:0] format_code, format_code_next;
  logic [15:0] channels, channels_next;
  logic [31:0] sample_rate, sample_rate_next;
  logic [31:0] byte_rate, byte_rate_next;
  logic [15:0] block_align, block_align_next;
  logic [15:0] bits, bits_next;
  logic [15:0] valid_bits, valid_bits_next;
  logic [15:0] sub_format, sub_format_next;
  logic [31:0] mask, mask_next;
  logic [31:0] fact_count, fact_count_next;
  logic [31:0] file_size, file_size_next;
  logic        ext_ok, ext_ok_next;

  logic        active;
  logic [1:0]  eff_idx;
  logic [31:0] eff_off;
  logic [31:0] word;
  logic [31:0] pos_inc;
  logic        chunk_done;
  logic [15:0] cb;
  logic        fmt_bad;
  logic        have_st;
  logic [2:0]  st;
  logic [7:0]  b;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      offset   <= '0;
      byte_idx <= '0;
    end else begin
      phase    <= phase_next;
      offset   <= offset_next;
      byte_idx <= byte_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    chunk_left  <= chunk_left_next;
    chunk_pos   <= chunk_pos_next;
    asm_lo      <= asm_lo_next;
    ext_len     <= ext_len_next;
    format_code <= format_code_next;
    channels    <= channels_next;
    sample_rate <= sample_rate_next;
    byte_rate   <= byte_rate_next;
    block_align <= block_align_next;
    bits        <= bits_next;
    valid_bits  <= valid_bits_next;
    sub_format  <= sub_format_next;
    mask        <= mask_next;
    fact_count  <= fact_count_next;
    file_size   <= file_size_next;
    ext_ok      <= ext_ok_next;
  end

  always_comb begin
    phase_next       = phase;
    offset_next      = offset;
    chunk_left_next  = chunk_left;
    chunk_pos_next   = chunk_pos;
    asm_lo_next      = asm_lo;
    byte_idx_next    = byte_idx;
    ext_len_next     = ext_len;
    format_code_next = format_code;
    channels_next    = channels;
    sample_rate_next = sample_rate;
    byte_rate_next   = byte_rate;
    block_align_next = block_align;
    bits_next        = bits;
    valid_bits_next  = valid_bits;
    sub_format_next  = sub_format;
    mask_next        = mask;
    fact_count_next  = fact_count;
    file_size_next   = file_size;
    ext_ok_next      = ext_ok;
    res_valid        = 1'b0;
    res              = '0;
    have_st          = 1'b0;
    st               = ST_OK;
    cb               = '0;
    fmt_bad          = 1'b0;

    b          = item.data_byte;
    active     = item.first_byte || (phase != PH_IDLE);
    cur        = item.first_byte ? PH_RIFF : phase;
    eff_idx    = item.first_byte ? 2'd0 : byte_idx;
    eff_off    = item.first_byte ? 32'd0 : offset;
    word       = {b, asm_lo};
    pos_inc    = chunk_pos + 32'd1;
    chunk_done = (chunk_left == 32'd1);

    if (step && active) begin
      phase_next  = cur;
      offset_next = eff_off + 32'd1;
      if (item.first_byte) begin
        fact_count_next = '0;
      end

      if (cur == PH_FMT || cur == PH_FACT) begin
        chunk_pos_next  = pos_inc;
        chunk_left_next = chunk_left - 32'd1;
        if (cur == PH_FMT) begin
          if (chunk_pos[31:5] == 27'd0) begin
            case (chunk_pos[4:0])
              5'd0:  format_code_next[7:0]  = b;
              5'd1:  format_code_next[15:8] = b;
              5'd2:  channels_next[7:0]     = b;
              5'd3:  channels_next[15:8]    = b;
              5'd4:  sample_rate_next[7:0]  = b;
              5'd5:  sample_rate_next[15:8] = b;
              5'd6:  sample_rate_next[23:16] = b;
              5'd7:  sample_rate_next[31:24] = b;
              5'd8:  byte_rate_next[7:0]    = b;
              5'd9:  byte_rate_next[15:8]   = b;
              5'd10: byte_rate_next[23:16]  = b;
              5'd11: byte_rate_next[31:24]  = b;
              5'd12: block_align_next[7:0]  = b;
              5'd13: block_align_next[15:8] = b;
              5'd14: bits_next[7:0]         = b;
              5'd15: bits_next[15:8]        = b;
              5'd16: ext_len_next[7:0]      = b;
              5'd17: ext_len_next[15:8]     = b;
              5'd18: valid_bits_next[7:0]   = b;
              5'd19: valid_bits_next[15:8]  = b;
              5'd20: mask_next[7:0]         = b;
              5'd21: mask_next[15:8]        = b;
              5'd22: mask_next[23:16]       = b;
              5'd23: mask_next[31:24]       = b;
              5'd24: sub_format_next[7:0]   = b;
              5'd25: sub_format_next[15:8]  = b;
              default: ;
            endcase
          end
          if (chunk_done) begin
            // closing checks use this byte's captures
            cb = (pos_inc >= FMT_EXT_BASE) ? ext_len_next : 16'd0;
            fmt_bad = (pos_inc < FMT_BASE_LEN) || (pos_inc == FMT_BASE_LEN + 32'd1) ||
                      ((cb != 16'd0) &&
                       ((cb < EXT_MIN_LEN) || ({16'd0, cb} > pos_inc - FMT_EXT_BASE)));
            ext_ok_next = (cb != 16'd0);
            if (fmt_bad) begin
              have_st = 1'b1;
              st      = ST_FMT;
            end else begin
              phase_next = PH_FACTID;
            end
          end
        end else begin
          if (chunk_pos[31:2] == 30'd0) begin
            fact_count_next[{chunk_pos[1:0], 3'b000} +: 8] = b;
          end
          if (chunk_done) begin
            if (pos_inc < 32'd4) begin
              have_st = 1'b1;
              st      = ST_FACT;
            end else begin
              phase_next = PH_DATAID;
            end
          end
        end
      end else begin
        byte_idx_next = eff_idx + 2'd1;
        case (eff_idx)
          2'd0:    asm_lo_next[7:0]   = b;
          2'd1:    asm_lo_next[15:8]  = b;
          2'd2:    asm_lo_next[23:16] = b;
          default: ;
        endcase
        if (eff_idx == 2'd3) begin
          case (cur)
            PH_RIFF: begin
              if (word == TAG_RIFF) phase_next = PH_FSIZE;
              else begin
                have_st = 1'b1;
                st      = ST_RIFF;
              end
            end
            PH_FSIZE: begin
              file_size_next = word;
              phase_next     = PH_WAVE;
            end
            PH_WAVE: begin
              if (word == TAG_WAVE) phase_next = PH_FMTID;
              else begin
                have_st = 1'b1;
                st      = ST_WAVE_FMT;
              end
            end
            PH_FMTID: begin
              if (word == TAG_FMT) phase_next = PH_FMTSIZE;
              else begin
                have_st = 1'b1;
                st      = ST_WAVE_FMT;
              end
            end
            PH_FMTSIZE: begin
              chunk_left_next = word;
              chunk_pos_next  = '0;
              ext_len_next    = '0;
              // an empty fmt chunk is always too short
              if (word == 32'd0) begin
                have_st = 1'b1;
                st      = ST_FMT;
              end else begin
                phase_next = PH_FMT;
              end
            end
            PH_FACTID: begin
              if (word == TAG_FACT) phase_next = PH_FACTSIZE;
              else if (word == TAG_DATA) phase_next = PH_DATASIZE;
              else begin
                have_st = 1'b1;
                st      = ST_FACT_TAG;
              end
            end
            PH_FACTSIZE: begin
              chunk_left_next = word;
              chunk_pos_next  = '0;
              if (word == 32'd0) begin
                have_st = 1'b1;
                st      = ST_FACT;
              end else begin
                phase_next = PH_FACT;
              end
            end
            PH_DATAID: begin
              if (word == TAG_DATA) phase_next = PH_DATASIZE;
              else begin
                have_st = 1'b1;
                st      = ST_DATA_TAG;
              end
            end
            PH_DATASIZE: begin
              have_st = 1'b1;
              st      = ST_OK;
            end
            default: begin
              phase_next = PH_IDLE;
            end
          endcase
        end
      end

      if (!have_st && item.last_byte) begin
        have_st = 1'b1;
        st      = ST_SHORT;
      end

      if (have_st) begin
        phase_next = PH_IDLE;
        res_valid  = 1'b1;
        res.status = st;
        if (st == ST_OK) begin
          res.format_tag        = ext_ok ? sub_format : format_code;
          res.channel_count     = channels;
          res.sample_rate       = sample_rate;
          res.byte_rate         = byte_rate;
          res.block_align       = block_align;
          res.bits_per_sample   = (ext_ok && bits == 16'd0) ? valid_bits : bits;
          res.channel_mask      = ext_ok ? mask : 32'd0;
          res.fact_sample_count = fact_count;
          res.data_size         = word;
          res.data_offset       = offset_next;
          res.file_size         = file_size;
        end
      end
    end
  end

endmodule

@@ rtl/wfhp_out_stage.sv @@
// ----------------------------------------------------------------------------
// wfhp_out_stage
// Result register holding one parse result until the receiver takes it.
// ----------------------------------------------------------------------------
module wfhp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  wfhp_pkg::result_t res_in,
  input  logic              out_ready,
  output logic              out_valid,
  output wfhp_pkg::result_t res_out
);
  import wfhp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

@@ rtl/wave_file_header_parser_top.sv @@
// ----------------------------------------------------------------------------
// wave_file_header_parser_top
// Byte-serial RIFF/WAVE header parser with one result per parse.
// ----------------------------------------------------------------------------
// Usage:
//   Header bytes enter on the s_ channel, one byte per transfer. s_tuser set
//   restarts parsing at that byte; s_tlast marks the last byte supplied.
//   Bytes seen while no parse is running and s_tuser is low are dropped.
//   One result leaves on the m_ channel per parse: status on m_tuser, and the
//   captured header fields on m_tdata (all zero unless status is ok).
// Timing:
//   One byte per cycle sustained while no result waits on m_tready low. A
//   byte is parsed by the per-byte update logic while it sits in the input
//   register, and the result register loads at the next edge; m_tvalid
//   rises when that register holds the result of the byte that ends a parse.
// Reset:
//   rst clears the parser to idle and empties both registers.
// Stall:
//   While a result waits on m_tready low, the parser stops and the input
//   register holds one more byte; after that s_tready drops.
// ----------------------------------------------------------------------------
module wave_file_header_parser_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tuser,   // first_byte
  input  logic         s_tlast,   // last_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [wfhp_pkg::OUT_TDATA_W-1:0] m_tdata,
  // m_tdata from bit 0: format_tag, channel_count, sample_rate, byte_rate,
  // block_align, bits_per_sample, channel_mask, fact_sample_count,
  // data_size, data_offset, file_size
  output logic [2:0]   m_tuser    // status
);
  import wfhp_pkg::*;

  in_item_t s_item;
  in_item_t in_item;
  logic     in_valid;
  logic     proc_fire;
  logic     res_valid;
  result_t  res;
  result_t  res_q;

  assign s_item = {s_tdata, s_tuser, s_tlast};

  // parse only when the result register can take whatever this byte yields
  assign proc_fire = in_valid && (!m_tvalid || m_tready);

  wfhp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (s_item),
    .take       (proc_fire),
    .held_valid (in_valid),
    .held_item  (in_item)
  );

  wfhp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (proc_fire),
    .item      (in_item),
    .res_valid (res_valid),
    .res       (res)
  );

  wfhp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res_in    (res),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .res_out   (res_q)
  );

  assign m_tuser = res_q.status;
  assign m_tdata = {res_q.file_size, res_q.data_offset, res_q.data_size,
                    res_q.fact_sample_count, res_q.channel_mask,
                    res_q.bits_per_sample, res_q.block_align, res_q.byte_rate,
                    res_q.sample_rate, res_q.channel_count, res_q.format_tag};

`ifndef SYNTHESIS
  a_err_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
    else $error("error result carries nonzero fields");

  a_first_last_result: assert property (@(posedge clk) disable iff (rst)
    (proc_fire && in_item.first_byte && in_item.last_byte) |-> res_valid)
    else $error("single-byte header produced no result");

  a_result_needs_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> proc_fire)
    else $error("result raised without a consumed byte");
`endif

endmodule

@@ tb/wave_file_header_parser_top_tb.sv @@
// ----------------------------------------------------------------------------
// wave_file_header_parser_top_tb
// Streams WAVE header bytes into the parser and compares every result
// against a predictor of the byte-serial parse. Directed headers hit each
// tag and size error, truncated streams and restarts. Random well-formed
// headers with random content, broken tags and noise follow, with idle
// cycles and backpressure on both sides.
// ----------------------------------------------------------------------------
module wave_file_header_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wfhp_pkg::*;

  localparam int QUIET_LIMIT = 1000;

  // where a header gets a damaged tag
  localparam int BREAK_NONE    = 0;
  localparam int BREAK_RIFF    = 1;
  localparam int BREAK_WAVE    = 2;
  localparam int BREAK_FMT     = 3;
  localparam int BREAK_FACT_ID = 4;
  localparam int BREAK_DATA_ID = 5;

  typedef struct {
    logic [7:0] data;
    logic       is_first;
    logic       is_last;
    bit         hold;
  } stream_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic s_tuser = 1'b0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [2:0] m_tuser;

  stream_byte_t byte_q[$];
  stream_byte_t cur_byte = '{8'h00, 1'b0, 1'b0, 1'b0};
  result_t      expected_results[$];
  result_t      want;

  bit          presenting = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          results_due = 0;
  int          results_done = 0;
  int          mismatches = 0;
  int          header_bytes = 0;
  int          quiet_cycles = 0;
  logic [31:0] cycle_no = '0;

  // parser copy
  phase_t      ph;
  logic [31:0] byte_pos;
  logic [31:0] body_left;
  logic [31:0] body_pos;
  logic [31:0] word_acc;
  logic [1:0]  word_idx;
  logic [15:0] ext_len;
  logic [63:0] cap_fields;
  logic [63:0] cap_rates;
  logic [63:0] cap_extras;
  logic [63:0] cap_sizes;

  wave_file_header_parser_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10ns clk = ~clk;

  function automatic void clear_parser();
    ph = PH_IDLE;
    byte_pos = '0;
    body_left = '0;
    body_pos = '0;
    word_acc = '0;
    word_idx = '0;
    ext_len = '0;
    cap_fields = '0;
    cap_rates = '0;
    cap_extras = '0;
    cap_sizes = '0;
  endfunction

  // fmt body layout: format, channels, rates, align, bits, ext length,
  // valid bits, channel mask, then the low word of the sub-format
  function automatic void fmt_store(input int unsigned p, input logic [7:0] b);
    if (p < 4) cap_fields[8*p +: 8] |= b;
    else if (p < 12) cap_rates[8*(p-4) +: 8] |= b;
    else if (p < 16) cap_fields[8*(p-8) +: 8] |= b;
    else if (p < 18) ext_len[8*(p-16) +: 8] |= b;
    else if (p < 20) word_acc[8*(p-18) +: 8] |= b;
    else if (p < 24) cap_extras[8*(p-20) +: 8] |= b;
    else if (p < 26) word_acc[8*(p-22) +: 8] |= b;
  endfunction

  // returns 1 when the fmt chunk is malformed
  function automatic bit fmt_close();
    logic [31:0] size;
    logic [15:0] cb;
    bit bad;
    size = body_pos;
    bad = 1'b0;
    if (size < FMT_BASE_LEN || size == FMT_BASE_LEN + 1) begin
      bad = 1'b1;
    end else begin
      cb = (size >= FMT_EXT_BASE) ? ext_len : 16'd0;
      if (cb != 0) begin
        if (cb < EXT_MIN_LEN || 32'(cb) > size - FMT_EXT_BASE) begin
          bad = 1'b1;
        end else begin
          cap_fields[15:0] = word_acc[31:16];
          if (cap_fields[63:48] == 16'd0) cap_fields[63:48] = word_acc[15:0];
        end
      end else begin
        cap_extras[31:0] = '0;
      end
    end
    word_acc = '0;
    return bad;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic is_first,
                                     input logic is_last);
    int st;
    logic [31:0] w;
    result_t r;
    st = -1;
    if (is_first) begin
      clear_parser();
      ph = PH_RIFF;
    end else if (ph == PH_IDLE) begin
      return;
    end
    byte_pos++;
    if (ph == PH_FMT || ph == PH_FACT) begin
      if (ph == PH_FMT) fmt_store(body_pos, b);
      else if (body_pos < 4) cap_extras[32 + 8*body_pos +: 8] |= b;
      body_pos++;
      body_left--;
      if (body_left == 0) begin
        if (ph == PH_FMT) begin
          if (fmt_close()) st = ST_FMT;
          else ph = PH_FACTID;
        end else if (body_pos < 4) begin
          st = ST_FACT;
        end else begin
          ph = PH_DATAID;
        end
      end
    end else begin
      word_acc[8*word_idx +: 8] |= b;
      word_idx++;
      if (word_idx == 2'd0) begin
        w = word_acc;
        word_acc = '0;
        case (ph)
          PH_RIFF: begin
            if (w == TAG_RIFF) ph = PH_FSIZE; else st = ST_RIFF;
          end
          PH_FSIZE: begin
            cap_sizes[31:0] = w;
            ph = PH_WAVE;
          end
          PH_WAVE: begin
            if (w == TAG_WAVE) ph = PH_FMTID; else st = ST_WAVE_FMT;
          end
          PH_FMTID: begin
            if (w == TAG_FMT) ph = PH_FMTSIZE; else st = ST_WAVE_FMT;
          end
          PH_FMTSIZE: begin
            body_left = w;
            body_pos = '0;
            ext_len = '0;
            // a zero-size chunk is judged right here
            if (w == 0) begin
              if (fmt_close()) st = ST_FMT;
              else ph = PH_FACTID;
            end else begin
              ph = PH_FMT;
            end
          end
          PH_FACTID: begin
            if (w == TAG_FACT) ph = PH_FACTSIZE;
            else if (w == TAG_DATA) ph = PH_DATASIZE;
            else st = ST_FACT_TAG;
          end
          PH_FACTSIZE: begin
            body_left = w;
            body_pos = '0;
            if (w == 0) st = ST_FACT; else ph = PH_FACT;
          end
          PH_DATAID: begin
            if (w == TAG_DATA) ph = PH_DATASIZE; else st = ST_DATA_TAG;
          end
          PH_DATASIZE: begin
            cap_sizes[63:32] = w;
            st = ST_OK;
          end
          default: begin
            ph = PH_IDLE;
            return;
          end
        endcase
      end
    end
    if (st < 0 && is_last) st = ST_SHORT;
    if (st >= 0) begin
      ph = PH_IDLE;
      r = '0;
      r.status = st[2:0];
      if (st == ST_OK) begin
        r.format_tag = cap_fields[15:0];
        r.channel_count = cap_fields[31:16];
        r.sample_rate = cap_rates[31:0];
        r.byte_rate = cap_rates[63:32];
        r.block_align = cap_fields[47:32];
        r.bits_per_sample = cap_fields[63:48];
        r.channel_mask = cap_extras[31:0];
        r.fact_sample_count = cap_extras[63:32];
        r.data_size = cap_sizes[63:32];
        r.data_offset = byte_pos;
        r.file_size = cap_sizes[31:0];
      end
      expected_results.push_back(r);
      results_due++;
    end
  endfunction

  // stimulus helpers
  function automatic void push_item(input logic [7:0] data, input logic is_first,
                                    input logic is_last, input bit hold);
    stream_byte_t it;
    it.data = data;
    it.is_first = is_first;
    it.is_last = is_last;
    it.hold = hold;
    byte_q.push_back(it);
  endfunction

  function automatic void put_word(ref logic [7:0] q[$], input logic [31:0] w);
    for (int i = 0; i < 4; i++) q.push_back(w[8*i +: 8]);
  endfunction

  function automatic logic [31:0] flip_bit(input logic [31:0] w);
    return w ^ (32'd1 << $urandom_range(0, 31));
  endfunction

  function automatic void add_noise(input int n, input int first_pct);
    for (int i = 0; i < n; i++)
      push_item(8'($urandom), $urandom_range(0, 99) < first_pct,
                $urandom_range(0, 7) == 0, 1'b0);
  endfunction

  // ext_val < 0 leaves the extension length bytes random; cut < 0 sends the
  // whole header, otherwise the stream stops at byte cut
  function automatic void add_header(input int broken, input logic [31:0] fmt_len,
                                     input int ext_val, input bit has_fact,
                                     input logic [31:0] fact_len, input int cut,
                                     input bit end_on_cut, input bit hold);
    logic [7:0] hb[$];
    logic [7:0] b;
    logic is_last;
    bit zero_bits;
    int n;
    zero_bits = $urandom_range(0, 2) == 0;
    put_word(hb, (broken == BREAK_RIFF) ? flip_bit(TAG_RIFF) : TAG_RIFF);
    put_word(hb, $urandom);
    put_word(hb, (broken == BREAK_WAVE) ? flip_bit(TAG_WAVE) : TAG_WAVE);
    put_word(hb, (broken == BREAK_FMT) ? flip_bit(TAG_FMT) : TAG_FMT);
    put_word(hb, fmt_len);
    n = (fmt_len > 64) ? 64 : int'(fmt_len);
    for (int p = 0; p < n; p++) begin
      b = 8'($urandom);
      if ((p == 14 || p == 15) && zero_bits) b = 8'h00;
      if (p == 16 && ext_val >= 0) b = ext_val[7:0];
      if (p == 17 && ext_val >= 0) b = ext_val[15:8];
      hb.push_back(b);
    end
    if (has_fact) begin
      put_word(hb, (broken == BREAK_FACT_ID) ? flip_bit(TAG_FACT) : TAG_FACT);
      put_word(hb, fact_len);
      n = (fact_len > 16) ? 16 : int'(fact_len);
      for (int p = 0; p < n; p++) hb.push_back(8'($urandom));
      put_word(hb, (broken == BREAK_DATA_ID) ? flip_bit(TAG_DATA) : TAG_DATA);
    end else begin
      put_word(hb, (broken == BREAK_FACT_ID || broken == BREAK_DATA_ID) ?
               flip_bit(TAG_DATA) : TAG_DATA);
    end
    put_word(hb, $urandom);
    for (int i = 0; i < hb.size(); i++) begin
      if (cut >= 0 && i > cut) break;
      if (i == cut) is_last = end_on_cut;
      else is_last = (cut < 0 && i == hb.size() - 1 && $urandom_range(0, 1) == 1);
      push_item(hb[i], i == 0, is_last, hold && i == 0);
      header_bytes++;
    end
  endfunction

  // idle gaps and stalls, none while bits 9:8 of cycle_no are zero
  function automatic int pick_gap();
    int r;
    if (cycle_no[9:8] == 2'b00) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(input string what, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, exp_val, got_val);
      mismatches++;
    end
  endtask

  // driver: predicts on each accepted byte
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      presenting = 1'b0;
      gap_left = 0;
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_byte(cur_byte.data, cur_byte.is_first, cur_byte.is_last);
        presenting = 1'b0;
        gap_left = pick_gap();
      end
      if (!presenting) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_q.size() > 0 &&
                     !(byte_q[0].hold && results_done != results_due)) begin
          cur_byte = byte_q.pop_front();
          presenting = 1'b1;
        end
      end
      s_tvalid <= presenting;
      s_tdata <= cur_byte.data;
      s_tuser <= cur_byte.is_first;
      s_tlast <= cur_byte.is_last;
    end
  end

  // monitor and result-side backpressure
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transfer with none expected, status %0d", $time, m_tuser);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          results_done <= results_done + 1;
          check_field("status", want.status, m_tuser);
          check_field("format_tag", want.format_tag, m_tdata[15:0]);
          check_field("channel_count", want.channel_count, m_tdata[31:16]);
          check_field("sample_rate", want.sample_rate, m_tdata[63:32]);
          check_field("byte_rate", want.byte_rate, m_tdata[95:64]);
          check_field("block_align", want.block_align, m_tdata[111:96]);
          check_field("bits_per_sample", want.bits_per_sample, m_tdata[127:112]);
          check_field("channel_mask", want.channel_mask, m_tdata[159:128]);
          check_field("fact_sample_count", want.fact_sample_count, m_tdata[191:160]);
          check_field("data_size", want.data_size, m_tdata[223:192]);
          check_field("data_offset", want.data_offset, m_tdata[255:224]);
          check_field("file_size", want.file_size, m_tdata[287:256]);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int pick;
    int room;
    int ext_val;
    int cut;
    int est;
    int broken;
    int case_no;
    bit has_fact;
    bit end_on_cut;
    logic [31:0] fmt_len;
    logic [31:0] fact_len;

    // bytes while idle are dropped
    push_item(8'h00, 1'b0, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b1, 1'b0);
    add_header(BREAK_NONE, 16, -1, 0, 0, -1, 0, 1);
    add_header(BREAK_NONE, 40, 22, 1, 4, -1, 0, 1);
    add_header(BREAK_NONE, 18, 0, 0, 0, -1, 0, 0);
    add_header(BREAK_NONE, 26, 8, 1, 12, -1, 0, 0);
    // fmt size errors: 17, zero, below base, short and oversized extension
    add_header(BREAK_NONE, 17, -1, 0, 0, -1, 0, 0);
    add_header(BREAK_NONE, 0, -1, 0, 0, -1, 0, 0);
    add_header(BREAK_NONE, 12, -1, 0, 0, -1, 0, 0);
    add_header(BREAK_NONE, 20, 4, 0, 0, -1, 0, 0);
    add_header(BREAK_NONE, 26, 9, 0, 0, -1, 0, 0);
    add_header(BREAK_NONE, 40, 16'hFFFF, 0, 0, -1, 0, 0);
    // fact too small, including zero size
    add_header(BREAK_NONE, 16, -1, 1, 0, -1, 0, 0);
    add_header(BREAK_NONE, 16, -1, 1, 3, -1, 0, 0);
    add_header(BREAK_RIFF, 16, -1, 0, 0, -1, 0, 0);
    add_header(BREAK_WAVE, 16, -1, 0, 0, -1, 0, 0);
    add_header(BREAK_FMT, 16, -1, 0, 0, -1, 0, 0);
    add_header(BREAK_FACT_ID, 16, -1, 1, 4, -1, 0, 0);
    add_header(BREAK_DATA_ID, 16, -1, 1, 4, -1, 0, 0);
    // early end: on the first byte, on a good tag, on a bad tag
    add_header(BREAK_NONE, 16, -1, 0, 0, 0, 1, 0);
    add_header(BREAK_NONE, 16, -1, 0, 0, 3, 1, 0);
    add_header(BREAK_RIFF, 16, -1, 0, 0, 3, 1, 0);
    add_header(BREAK_NONE, 32'hFFFF_FFFF, -1, 0, 0, 30, 1, 0);
    add_header(BREAK_NONE, 16, -1, 1, 32'hFFFF_FFFF, 50, 1, 0);
    // end lands on the byte closing a bad fmt chunk
    add_header(BREAK_NONE, 17, -1, 0, 0, 36, 1, 0);
    // restart in the middle of a header
    add_header(BREAK_NONE, 40, 22, 0, 0, 30, 0, 0);
    add_noise(12, 25);

    case_no = 0;
    while (header_bytes < 2000) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) fmt_len = 16;
      else if (pick < 55) fmt_len = 18;
      else if (pick < 75) fmt_len = 40;
      else if (pick < 90) fmt_len = $urandom_range(17, 48);
      else fmt_len = $urandom_range(0, 15);
      ext_val = -1;
      if (fmt_len >= 18) begin
        room = fmt_len - 18;
        pick = $urandom_range(0, 99);
        if (pick < 25) ext_val = 0;
        else if (pick < 40) ext_val = $urandom_range(1, 7);
        else if (pick < 85) ext_val = (room >= 8) ? $urandom_range(8, room) : 0;
        else ext_val = room + $urandom_range(1, 8);
      end
      has_fact = $urandom_range(0, 99) < 40;
      fact_len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 12);
      broken = ($urandom_range(0, 99) < 72) ? BREAK_NONE :
               $urandom_range(BREAK_RIFF, BREAK_DATA_ID);
      cut = -1;
      end_on_cut = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        est = 28 + int'(fmt_len) + (has_fact ? 8 + int'(fact_len) : 0);
        cut = $urandom_range(0, est - 1);
        end_on_cut = $urandom_range(0, 99) < 85;
      end
      add_header(broken, fmt_len, ext_val, has_fact, fact_len, cut, end_on_cut,
                 case_no % 8 == 0);
      case_no++;
      if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 6), 0);
      if ($urandom_range(0, 19) == 0) add_noise($urandom_range(4, 20), 15);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (byte_q.size() > 0 || presenting || results_done != results_due);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
